FILE: sv/dotq_pkg.sv
// shared types, constants and helpers for the deadline ordered frame timer queue
package dotq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DELAY_BITS  = 16;
  localparam int SLOT_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [31:0] DELAY_MAX32 = 32'((64'd1 << DELAY_BITS) - 64'd1);

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic STATUS_SENT = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic [15:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_id;
    logic [3:0]  out_length;
    logic [63:0] out_payload;
    logic        status;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [31:0]           id;
    logic [3:0]            length;
    logic [63:0]           payload;
    logic [DELAY_BITS-1:0] countdown;
    logic [SLOT_BITS-1:0]  slot;
  } entry_t;

  typedef struct packed {
    logic   valid;
    logic   due;
    entry_t ent;
  } cell_state_t;

  typedef struct packed {
    logic insert;
    logic remove;
    logic mark;
    logic dec;
    logic clear;
  } cell_cmd_t;

  // links passed from one cell to the next
  typedef struct packed {
    logic lt;
    logic gone;
  } cell_link_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_EMIT,
    ST_DEC,
    ST_INS,
    ST_REJ,
    ST_CLR
  } state_t;

  // clamp a requested delay to the countdown width
  function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [15:0] d);
    logic [31:0] dx;
    dx = 32'(d);
    if (dx > DELAY_MAX32) begin
      sat_delay = '1;
    end else begin
      sat_delay = DELAY_BITS'(dx);
    end
  endfunction

endpackage

FILE: sv/dotq_cell.sv
// one queue cell: holds a frame, stays sorted by (id, slot) with its neighbors
module dotq_cell import dotq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  input  entry_t      new_ent,
  input  cell_state_t prev_st,
  input  cell_state_t next_st,
  input  cell_link_t  prev_link,
  output cell_state_t st_o,
  output cell_link_t  link_o,
  output logic        first_o
);

  logic   valid_r, valid_nxt;
  logic   due_r, due_nxt;
  entry_t ent_r, ent_nxt;

  always_comb begin
    link_o.lt   = !valid_r || ({new_ent.id, new_ent.slot} < {ent_r.id, ent_r.slot});
    link_o.gone = prev_link.gone | due_r;
    first_o     = due_r & !prev_link.gone;
  end

  always_comb begin
    valid_nxt = valid_r;
    due_nxt   = due_r;
    ent_nxt   = ent_r;
    if (cmd.clear) begin
      valid_nxt = 1'b0;
      due_nxt   = 1'b0;
    end else if (cmd.insert) begin
      if (prev_link.lt) begin
        valid_nxt = prev_st.valid;
        due_nxt   = prev_st.due;
        ent_nxt   = prev_st.ent;
      end else if (link_o.lt) begin
        valid_nxt = 1'b1;
        due_nxt   = 1'b0;
        ent_nxt   = new_ent;
      end
    end else if (cmd.remove) begin
      // cells from the removed one upward shift down by one
      if (link_o.gone) begin
        valid_nxt = next_st.valid;
        due_nxt   = next_st.due;
        ent_nxt   = next_st.ent;
      end
    end else if (cmd.mark) begin
      due_nxt = valid_r && (ent_r.countdown == '0);
    end else if (cmd.dec) begin
      if (valid_r && (ent_r.countdown != '0)) begin
        ent_nxt.countdown = ent_r.countdown - DELAY_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      due_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      due_r   <= due_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign st_o = '{valid: valid_r, due: due_r, ent: ent_r};

endmodule

FILE: sv/deadline_ordered_frame_timer_queue_unit.sv
// top level of the deadline ordered frame timer queue
//
// input channel (in_valid, in_stall, in_data): one transaction is a tick, a
// frame push or a clear. the block takes one transaction at a time and holds
// in_stall high while it works on it.
// result channel (out_valid, out_stall, out_data): frames that fall due on a
// tick, ordered by lower identifier first and lower slot on ties, and pushes
// rejected because the queue is full. last_of_run marks the final result of
// the transaction that caused it.
// the frames sit in a row of cells kept sorted by (identifier, slot), so the
// next due frame is always the lowest due cell; sending it shifts the cells
// above it down by one.
// steps: a push passes through an insert state and a clear through a clear
// state before the next transaction can be taken; a rejected push waits until
// the output register is free; a tick marks the due cells, sends the due frames
// in order, each once the output register is free, then counts the rest down.
// a stalled receiver holds the current result in the output register and
// pauses the sending of further frames; nothing is lost.
// reset empties the queue and the output register; frame storage itself
// is not cleared, since only valid cells are ever read.
module deadline_ordered_frame_timer_queue_unit import dotq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  state_t state_r, state_nxt;
  in_item_t hold_r;

  logic [QUEUE_DEPTH-1:0] slot_used_r, slot_used_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  cell_cmd_t   cmd;
  entry_t      new_ent;
  cell_state_t st   [QUEUE_DEPTH];
  cell_link_t  link [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] first_vec;
  logic [QUEUE_DEPTH-1:0] due_vec;

  logic                 in_take;
  logic                 out_free;
  logic                 queue_full;
  logic [SLOT_BITS-1:0] free_idx;
  entry_t               sel_ent;
  logic                 any_due;
  logic                 last_emit;
  logic                 emit_go;
  logic                 rej_go;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // lowest free slot, searched from the top so the lowest index wins
  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        free_idx = SLOT_BITS'(i);
      end
    end
  end
  assign queue_full = &slot_used_r;

  always_comb begin
    new_ent.id        = hold_r.frame_id;
    new_ent.length    = hold_r.frame_length;
    new_ent.payload   = hold_r.frame_payload;
    new_ent.countdown = sat_delay(hold_r.delay_ticks);
    new_ent.slot      = free_idx;
  end

  // the cell chain
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    cell_state_t prev_st, next_st;
    cell_link_t  prev_link;
    if (g == 0) begin : g_head
      assign prev_st   = '0;
      assign prev_link = '0;
    end else begin : g_body
      assign prev_st   = st[g-1];
      assign prev_link = link[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_st = '0;
    end else begin : g_mid
      assign next_st = st[g+1];
    end

    dotq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .new_ent   (new_ent),
      .prev_st   (prev_st),
      .next_st   (next_st),
      .prev_link (prev_link),
      .st_o      (st[g]),
      .link_o    (link[g]),
      .first_o   (first_vec[g])
    );

    assign due_vec[g] = st[g].due;
  end

  // pick the lowest due cell
  always_comb begin
    sel_ent = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (first_vec[i]) begin
        sel_ent = sel_ent | st[i].ent;
      end
    end
  end

  assign any_due   = |due_vec;
  assign last_emit = ~|(due_vec & (due_vec - QUEUE_DEPTH'(1)));
  assign emit_go   = (state_r == ST_EMIT) && any_due && out_free;
  assign rej_go    = (state_r == ST_REJ) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_data.operation)
            OP_TICK:  state_nxt = ST_MARK;
            OP_PUSH:  state_nxt = queue_full ? ST_REJ : ST_INS;
            OP_CLEAR: state_nxt = ST_CLR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MARK: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!any_due || (emit_go && last_emit)) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC:  state_nxt = ST_IDLE;
      ST_INS:  state_nxt = ST_IDLE;
      ST_REJ:  state_nxt = rej_go ? ST_IDLE : ST_REJ;
      ST_CLR:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // cell commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_MARK: cmd.mark   = 1'b1;
      ST_EMIT: cmd.remove = emit_go;
      ST_DEC:  cmd.dec    = 1'b1;
      ST_INS:  cmd.insert = 1'b1;
      ST_CLR:  cmd.clear  = 1'b1;
      default: cmd = '0;
    endcase
  end

  // slot bookkeeping and the output register
  always_comb begin
    slot_used_nxt = slot_used_r;
    if (state_r == ST_INS) begin
      slot_used_nxt[free_idx] = 1'b1;
    end else if (state_r == ST_CLR) begin
      slot_used_nxt = '0;
    end else if (emit_go) begin
      slot_used_nxt[sel_ent.slot] = 1'b0;
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (emit_go) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_id      = sel_ent.id;
      out_data_nxt.out_length  = sel_ent.length;
      out_data_nxt.out_payload = sel_ent.payload;
      out_data_nxt.status      = STATUS_SENT;
      out_data_nxt.last_of_run = last_emit;
    end else if (rej_go) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_id      = hold_r.frame_id;
      out_data_nxt.out_length  = hold_r.frame_length;
      out_data_nxt.out_payload = hold_r.frame_payload;
      out_data_nxt.status      = STATUS_FULL;
      out_data_nxt.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_used_r <= slot_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_take) begin
      hold_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/tb_deadline_ordered_frame_timer_queue_unit.sv
// self-checking testbench for the deadline ordered frame timer queue unit
module tb_deadline_ordered_frame_timer_queue_unit;
  import dotq_pkg::*;

  // the one operation code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int GAP_MAX      = 18;    // longest wait either side draws
  localparam int IDLE_LIMIT   = 3000;  // cycles with no transaction before giving up
  localparam int RANDOM_ITEMS = 350;
  localparam int MAX_SHOWN    = 10;
  localparam int TAIL_CYCLES  = 40;

  // one queued stimulus transaction with its lead-in gap
  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          hold_for_drain;
  } cmd_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  deadline_ordered_frame_timer_queue_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // shadow copy of the queue slots
  logic [31:0]           slot_id      [QUEUE_DEPTH];
  logic [3:0]            slot_len     [QUEUE_DEPTH];
  logic [63:0]           slot_payload [QUEUE_DEPTH];
  logic [DELAY_BITS-1:0] slot_left    [QUEUE_DEPTH];
  bit                    slot_used    [QUEUE_DEPTH];

  out_item_t pending_frames[$];  // frames the block still owes, oldest first
  cmd_t      frame_cmds[$];      // transactions not yet offered

  // handshake flags passed from the rising edge to the falling edge
  bit took_cmd   = 1'b0;
  bit took_frame = 1'b0;

  cmd_t        cur_cmd;
  bit          loaded     = 1'b0;
  int unsigned stall_left = 0;
  bit          tx_calm    = 1'b0;  // sender runs back to back while set
  bit          rx_calm    = 1'b0;  // receiver never stalls while set
  int          errors     = 0;
  int          reports    = 0;
  int          quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // next-state and result prediction for one accepted transaction
  // ---------------------------------------------------------------------
  function automatic void advance_timer_queue(in_item_t it);
    bit        sent [QUEUE_DEPTH];
    int        n_due;
    int        pick;
    out_item_t r;
    n_due = 0;
    pick  = -1;
    for (int s = 0; s < QUEUE_DEPTH; s++) begin
      sent[s] = 1'b0;
    end
    case (it.operation)
      OP_TICK: begin
        // frames already at zero go out now, lowest id first, lowest slot on ties
        for (int s = 0; s < QUEUE_DEPTH; s++) begin
          if (slot_used[s] && slot_left[s] == '0) n_due++;
        end
        for (int k = 0; k < n_due; k++) begin
          pick = -1;
          for (int s = 0; s < QUEUE_DEPTH; s++) begin
            if (slot_used[s] && slot_left[s] == '0 && !sent[s] &&
                (pick < 0 || slot_id[s] < slot_id[pick])) pick = s;
          end
          sent[pick]    = 1'b1;
          r.out_id      = slot_id[pick];
          r.out_length  = slot_len[pick];
          r.out_payload = slot_payload[pick];
          r.status      = STATUS_SENT;
          r.last_of_run = (k == n_due - 1);
          pending_frames.push_back(r);
        end
        // then everything still waiting counts down by one
        for (int s = 0; s < QUEUE_DEPTH; s++) begin
          if (sent[s]) begin
            slot_used[s] = 1'b0;
          end else if (slot_used[s] && slot_left[s] != '0) begin
            slot_left[s] = slot_left[s] - DELAY_BITS'(1);
          end
        end
      end
      OP_PUSH: begin
        for (int s = 0; s < QUEUE_DEPTH; s++) begin
          if (!slot_used[s] && pick < 0) pick = s;
        end
        if (pick < 0) begin
          // no room: the frame comes straight back flagged as rejected
          r.out_id      = it.frame_id;
          r.out_length  = it.frame_length;
          r.out_payload = it.frame_payload;
          r.status      = STATUS_FULL;
          r.last_of_run = 1'b1;
          pending_frames.push_back(r);
        end else begin
          slot_used[pick]    = 1'b1;
          slot_id[pick]      = it.frame_id;
          slot_len[pick]     = it.frame_length;
          slot_payload[pick] = it.frame_payload;
          slot_left[pick]    = (32'(it.delay_ticks) > DELAY_MAX32) ? '1
                                                                   : DELAY_BITS'(it.delay_ticks);
        end
      end
      OP_CLEAR: begin
        for (int s = 0; s < QUEUE_DEPTH; s++) begin
          slot_used[s] = 1'b0;
        end
      end
      default: begin
        // unused code leaves the queue alone
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int unsigned draw_wait(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  // random junk in every field; the block must only look at what the op needs
  function automatic in_item_t noise_item(logic [1:0] op);
    in_item_t it;
    it.operation     = op;
    it.frame_id      = $urandom;
    it.frame_length  = 4'($urandom_range(0, 15));
    it.frame_payload = {$urandom, $urandom};
    it.delay_ticks   = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t frame_push(logic [31:0] id, logic [3:0] len,
                                          logic [63:0] payload, logic [15:0] dly);
    in_item_t it;
    it.operation     = OP_PUSH;
    it.frame_id      = id;
    it.frame_length  = len;
    it.frame_payload = payload;
    it.delay_ticks   = dly;
    return it;
  endfunction

  // ids from a tiny pool most of the time so that ties on one tick are common
  function automatic in_item_t random_push();
    in_item_t it;
    it = noise_item(OP_PUSH);
    if ($urandom_range(0, 3) != 0) it.frame_id = 32'($urandom_range(0, 7));
    if ($urandom_range(0, 19) != 0) it.delay_ticks = 16'($urandom_range(0, 5));
    return it;
  endfunction

  task automatic queue_cmd(in_item_t it, bit hold);
    cmd_t c;
    c.item           = it;
    c.gap            = draw_wait(tx_calm);
    c.hold_for_drain = hold;
    frame_cmds.push_back(c);
  endtask

  // ---------------------------------------------------------------------
  // driver: offers queued transactions on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took_cmd)) begin
      took_cmd = 1'b0;
      if (!loaded && frame_cmds.size() != 0) begin
        cur_cmd = frame_cmds.pop_front();
        loaded  = 1'b1;
      end
      if (loaded && cur_cmd.gap != 0) begin
        cur_cmd.gap--;
        in_valid <= 1'b0;
      end else if (loaded && !(cur_cmd.hold_for_drain && pending_frames.size() != 0)) begin
        // a held transaction goes only once every owed frame has come back
        in_valid <= 1'b1;
        in_data  <= cur_cmd.item;
        loaded    = 1'b0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: stall drawn per result, counted down only while a result waits
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (took_frame) begin
      took_frame = 1'b0;
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall_left = draw_wait(rx_calm);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      if (out_valid) stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks results and feeds the predictor on the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      // result check first: a result never belongs to a transaction taken this edge
      if (out_valid && !out_stall) begin
        took_frame = 1'b1;
        if (pending_frames.size() == 0) begin
          errors++;
          reports++;
          if (reports <= MAX_SHOWN)
            $display("unexpected frame: id %h len %0d payload %h status %0d last %0d",
                     out_data.out_id, out_data.out_length, out_data.out_payload,
                     out_data.status, out_data.last_of_run);
        end else begin
          want = pending_frames.pop_front();
          if (out_data.out_id !== want.out_id || out_data.out_length !== want.out_length ||
              out_data.out_payload !== want.out_payload || out_data.status !== want.status ||
              out_data.last_of_run !== want.last_of_run) begin
            errors++;
            reports++;
            if (reports <= MAX_SHOWN) begin
              $display("frame mismatch at %0t", $realtime);
              $display("  id      got %h want %h", out_data.out_id, want.out_id);
              $display("  length  got %0d want %0d", out_data.out_length, want.out_length);
              $display("  payload got %h want %h", out_data.out_payload, want.out_payload);
              $display("  status  got %0d want %0d", out_data.status, want.status);
              $display("  last    got %0d want %0d", out_data.last_of_run, want.last_of_run);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        took_cmd = 1'b1;
        advance_timer_queue(in_data);
      end
    end
  end

  // watchdog on cycles where neither channel moves a transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int n_rand;
    int kind;
    n_rand = 0;

    // directed: empty queue corner cases
    queue_cmd(noise_item(OP_TICK), 1'b0);
    queue_cmd(noise_item(OP_CLEAR), 1'b0);
    queue_cmd(noise_item(OP_UNUSED), 1'b0);
    // field extremes, length above 8, equal ids on one tick
    queue_cmd(frame_push(32'h0, 4'd0, 64'h0, 16'd0), 1'b0);
    queue_cmd(frame_push(32'hFFFF_FFFF, 4'd15, '1, 16'd0), 1'b0);
    queue_cmd(frame_push(32'h0000_0123, 4'd8, 64'h0123_4567_89AB_CDEF, 16'd0), 1'b0);
    queue_cmd(noise_item(OP_UNUSED), 1'b0);
    queue_cmd(frame_push(32'h0000_0123, 4'd1, 64'hFEDC_BA98_7654_3210, 16'd0), 1'b0);
    queue_cmd(noise_item(OP_TICK), 1'b0);
    // wait for those four frames before going on
    queue_cmd(frame_push(32'h0000_0055, 4'd8, 64'hA5A5_5A5A_F00F_0FF0, 16'hFFFF), 1'b1);
    queue_cmd(frame_push(32'h0000_00AA, 4'd2, 64'h1, 16'd1), 1'b0);
    queue_cmd(noise_item(OP_TICK), 1'b0);
    queue_cmd(noise_item(OP_TICK), 1'b0);
    // clear drops the long-delay frame
    queue_cmd(noise_item(OP_CLEAR), 1'b0);
    queue_cmd(noise_item(OP_TICK), 1'b0);

    // random: mostly pushes and ticks, with fill bursts that overflow the queue
    while (n_rand < RANDOM_ITEMS) begin
      if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        repeat (QUEUE_DEPTH + 2) queue_cmd(random_push(), 1'b0);
        repeat (5) queue_cmd(noise_item(OP_TICK), 1'b0);
        n_rand += QUEUE_DEPTH + 7;
      end else if (kind == 1) begin
        queue_cmd(noise_item(OP_CLEAR), 1'b0);
        n_rand++;
      end else if (kind == 2) begin
        // ignored code, not counted toward the item total
        queue_cmd(noise_item(OP_UNUSED), 1'b0);
      end else if (kind <= 10) begin
        queue_cmd(random_push(), $urandom_range(0, 59) == 0);
        n_rand++;
      end else begin
        queue_cmd(noise_item(OP_TICK), $urandom_range(0, 59) == 0);
        n_rand++;
      end
    end

    // synchronous reset, released on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // run until every transaction is in and every owed frame is back
    while (frame_cmds.size() != 0 || loaded || in_valid || pending_frames.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending_frames.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
